// ----- rtl/core/sha256_byte_stream_hasher_defines.svh -----
// Assertion macros used by the byte-stream hasher module.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sha256_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the round engine.
    typedef struct packed {
        logic       start;
        logic       round_en;
        logic [5:0] round;
        logic       add_en;
    } eng_ctrl_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

endpackage
`default_nettype wire

// ----- rtl/core/sha256_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Round engine. The message schedule is a 16-word window written with one word
// per round and read at fixed offsets from the round index; words 0..15 come
// from the block memory read port supplied by the caller.
module sha256_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sha256_pkg::eng_ctrl_t ctrl,
    input  wire logic [31:0]          blk_word,
    input  wire logic                 reinit,
    input  wire logic [2:0]           rd_idx,
    output logic [31:0]               rd_word
);
    logic [31:0] sched_mem [16];
    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w, s0, s1, t1, t2, ch, mj, e1, e0;
    logic [3:0]  r4;

    assign r4 = ctrl.round[3:0];

    // Schedule word for this round.
    always_comb begin
        s1 = {sched_mem[r4 - 4'd2][16:0], sched_mem[r4 - 4'd2][31:17]}
           ^ {sched_mem[r4 - 4'd2][18:0], sched_mem[r4 - 4'd2][31:19]}
           ^ (sched_mem[r4 - 4'd2] >> 10);
        s0 = {sched_mem[r4 - 4'd15][6:0], sched_mem[r4 - 4'd15][31:7]}
           ^ {sched_mem[r4 - 4'd15][17:0], sched_mem[r4 - 4'd15][31:18]}
           ^ (sched_mem[r4 - 4'd15] >> 3);
        if (ctrl.round < 6'd16) begin
            w = blk_word;
        end else begin
            w = s1 + sched_mem[r4 - 4'd7] + s0 + sched_mem[r4];
        end
        e1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
           ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        e0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
           ^ {v_reg[0][21:0], v_reg[0][31:22]};
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + e1 + ch + sha256_pkg::ROUND_K[ctrl.round] + w;
        t2 = e0 + mj;
    end

    // Schedule window storage.
    always_ff @(posedge aclk) begin
        if (ctrl.round_en) begin
            sched_mem[r4] <= w;
        end
    end

    // Working variables and chaining value.
    always_ff @(posedge aclk) begin
        if (!aresetn || reinit) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= sha256_pkg::H_INIT[i];
        end else if (ctrl.add_en) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
        end else if (ctrl.round_en) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign rd_word = chain_reg[rd_idx];

endmodule
`default_nettype wire

// ----- rtl/core/sha256_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 over a byte stream.
// Input beats carry msg_byte on s_axis_tdata, byte_present on s_axis_tuser and
// msg_end on s_axis_tlast. Bytes go into a 16-word block memory, one per beat
// with byte_present set, and s_axis_tready is low whenever the block pads,
// compresses or presents a digest. A compression runs a load step, 64 rounds
// and an add step. After an end beat with n bytes pending, padding fills the
// rest of the block and one compression follows; for n above 55 a second
// padding block and its compression are added, and an end beat that fills a
// block has that block compressed before the padding block and its compression.
// Eight digest beats then follow on m_axis, word 0 first: tdata holds
// digest_word with word_index above it, and tlast marks word 7. Each beat
// holds while the receiver stalls; no input is taken until the digest is out.
// After the eighth beat, and at reset (aresetn low, synchronous), the chaining
// value, count and fill return to their initial values and control is cleared;
// the block memory is not cleared and needs no clearing pass.
module sha256_byte_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // msg_byte[7:0]
    input  wire logic        s_axis_tuser,  // byte_present
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // digest_word[31:0], word_index[34:32]
    output logic             m_axis_tlast
);
`include "sha256_byte_stream_hasher_defines.svh"

    sha256_pkg::state_t state_reg, state_next;
    logic [3:0][7:0] blk_mem [16];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;
    logic        final_reg, final_next, two_reg, two_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [31:0] blk_word;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [31:0] rd_word;
    logic        reinit, acc;
    logic        pend_reg, pend_next, pend_end;
    logic [5:0]  padpos_reg, padpos_next;
    logic        padded_reg, padded_next;
    sha256_pkg::eng_ctrl_t ctrl;

    assign acc = s_axis_tvalid && s_axis_tready;

    // Block memory: one byte-lane write, one registered word read, big-endian lanes.
    always_ff @(posedge aclk) begin
        if (wr_en) blk_mem[wr_addr[5:2]][2'd3 - wr_addr[1:0]] <= wr_data;
        blk_word <= blk_mem[cnt_next[3:0]];
    end

    sha256_engine u_eng (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .blk_word(blk_word),
        .reinit(reinit), .rd_idx(oidx_reg), .rd_word(rd_word)
    );

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        total_next = total_reg;
        final_next = final_reg;
        two_next   = two_reg;
        cnt_next   = cnt_reg;
        oidx_next  = oidx_reg;
        case (state_reg)
            sha256_pkg::ST_COLLECT: begin
                if (acc) begin
                    if (s_axis_tuser) begin
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            bits_next  = bits_reg + 64'd512;
                            final_next = 1'b0;
                            two_next   = 1'b0;
                            cnt_next   = 7'd0;
                            state_next = sha256_pkg::ST_LOAD;
                            if (s_axis_tlast) begin
                                total_next = bits_reg + 64'd512;
                            end
                        end else if (s_axis_tlast) begin
                            total_next = bits_reg + {55'd0, fill_reg + 6'd1, 3'd0};
                            two_next   = (fill_reg + 6'd1) > 6'd55;
                            cnt_next   = {1'b0, fill_reg + 6'd1};
                            state_next = sha256_pkg::ST_PAD;
                        end
                    end else if (s_axis_tlast) begin
                        total_next = bits_reg + {55'd0, fill_reg, 3'd0};
                        two_next   = fill_reg > 6'd55;
                        cnt_next   = {1'b0, fill_reg};
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                // Pad byte at the fill position (first padding block only), then zeros or length bytes.
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    final_next = !two_reg;
                    cnt_next   = 7'd0;
                    state_next = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD: begin
                cnt_next   = 7'd0;
                state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) state_next = sha256_pkg::ST_ADD;
            end
            sha256_pkg::ST_ADD: begin
                cnt_next = 7'd0;
                if (final_reg) begin
                    oidx_next  = 3'd0;
                    state_next = sha256_pkg::ST_EMIT;
                end else if (two_reg || pend_end) begin
                    two_next   = 1'b0;
                    state_next = sha256_pkg::ST_PAD;
                end else begin
                    state_next = sha256_pkg::ST_COLLECT;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (m_axis_tready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        fill_next  = 6'd0;
                        bits_next  = 64'd0;
                        final_next = 1'b0;
                        state_next = sha256_pkg::ST_COLLECT;
                    end
                end
            end
            default: state_next = sha256_pkg::ST_COLLECT;
        endcase
    end

    // An end beat that completed a full block still needs a padding block.
    assign pend_end = pend_reg;
    always_comb begin
        pend_next = pend_reg;
        if (state_reg == sha256_pkg::ST_COLLECT && acc && s_axis_tuser
            && s_axis_tlast && fill_reg == 6'd63) begin
            pend_next = 1'b1;
        end else if (state_reg == sha256_pkg::ST_ADD) begin
            pend_next = 1'b0;
        end
    end

    // Outputs and memory writes.
    always_comb begin
        s_axis_tready = (state_reg == sha256_pkg::ST_COLLECT);
        m_axis_tvalid = (state_reg == sha256_pkg::ST_EMIT);
        m_axis_tdata  = {5'd0, oidx_reg, rd_word};
        m_axis_tlast  = (oidx_reg == 3'd7);
        reinit        = (state_reg == sha256_pkg::ST_EMIT) && m_axis_tready
                        && (oidx_reg == 3'd7);
        ctrl.start    = (state_reg == sha256_pkg::ST_LOAD);
        ctrl.round_en = (state_reg == sha256_pkg::ST_ROUND);
        ctrl.round    = cnt_reg[5:0];
        ctrl.add_en   = (state_reg == sha256_pkg::ST_ADD);
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = s_axis_tdata;
        if (state_reg == sha256_pkg::ST_COLLECT) begin
            wr_en = acc && s_axis_tuser;
        end else if (state_reg == sha256_pkg::ST_PAD) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[5:0];
            if (!padded_reg && cnt_reg[5:0] == padpos_reg) begin
                wr_data = sha256_pkg::PAD_BYTE;
            end else if (cnt_reg[5:0] >= sha256_pkg::LEN_START && !two_reg) begin
                wr_data = total_reg[{3'd7 - cnt_reg[2:0], 3'd0} +: 8];
            end else begin
                wr_data = 8'd0;
            end
        end
    end

    // Position that takes the 0x80 byte; a second padding block has none.
    always_comb begin
        padpos_next = padpos_reg;
        padded_next = padded_reg;
        if (state_reg != sha256_pkg::ST_PAD && state_next == sha256_pkg::ST_PAD) begin
            padpos_next = cnt_next[5:0];
        end
        if (state_reg == sha256_pkg::ST_PAD && cnt_reg == 7'd63) begin
            padded_next = 1'b1;
        end
        if (state_reg == sha256_pkg::ST_EMIT) padded_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sha256_pkg::ST_COLLECT;
            fill_reg   <= 6'd0;
            bits_reg   <= 64'd0;
            final_reg  <= 1'b0;
            two_reg    <= 1'b0;
            cnt_reg    <= 7'd0;
            oidx_reg   <= 3'd0;
            pend_reg   <= 1'b0;
            padded_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            final_reg  <= final_next;
            two_reg    <= two_next;
            cnt_reg    <= cnt_next;
            oidx_reg   <= oidx_next;
            pend_reg   <= pend_next;
            padded_reg <= padded_next;
        end
        total_reg  <= total_next;
        padpos_reg <= padpos_next;
    end

    `SHA_ASSERT_IMPL(a_no_in_emit, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "input taken during digest")
    `SHA_ASSERT_NEXT(a_hold_word, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(oidx_reg), "digest beat changed while stalled")
    `SHA_ASSERT_NEXT(a_round_to_add, aclk, aresetn, state_reg == sha256_pkg::ST_ROUND && cnt_reg == 7'd63, state_reg == sha256_pkg::ST_ADD, "round count overran")

endmodule
`default_nettype wire
